[rtl/sfcs_pkg.sv]
// ----------------------------------------------------------------------------
// sfcs_pkg
// Shared types and constants of the serial NOR flash command sequencer.
// ----------------------------------------------------------------------------
package sfcs_pkg;

  // Default sizes.
  localparam int unsigned DEF_BUFFER_BYTES = 256;
  localparam int unsigned DEF_PAGE_BYTES   = 256;

  // Flash command and filler bytes.
  localparam logic [7:0] CMD_READ_ID   = 8'h9F;
  localparam logic [7:0] CMD_READ      = 8'h03;
  localparam logic [7:0] CMD_RESET_EN  = 8'h66;
  localparam logic [7:0] CMD_RESET     = 8'h99;
  localparam logic [7:0] CMD_WRITE_EN  = 8'h06;
  localparam logic [7:0] CMD_PAGE_PROG = 8'h02;
  localparam logic [7:0] CMD_CHIP_ERA  = 8'hC7;
  localparam logic [7:0] DUMMY_BYTE    = 8'hFF;
  localparam logic [7:0] MAKER_ID_RST  = 8'hEF;

  localparam logic [23:0] PAGE_STRIDE  = 24'd256;

  // Request kinds on the input stream.
  localparam logic FUNC_START     = 1'b0;
  localparam logic FUNC_BYTE_DONE = 1'b1;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_START_ADDR = 2'd1;
  localparam logic [1:0] REG_MAKER_ID   = 2'd2;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

  // Phase numbers as reported on the result stream.
  localparam logic [3:0] PH_RST_EN   = 4'd0;
  localparam logic [3:0] PH_DEV_RST  = 4'd1;
  localparam logic [3:0] PH_ID_CMD   = 4'd2;
  localparam logic [3:0] PH_ID1      = 4'd3;
  localparam logic [3:0] PH_ID2      = 4'd4;
  localparam logic [3:0] PH_ID3      = 4'd5;
  localparam logic [3:0] PH_IDLE     = 4'd6;
  localparam logic [3:0] PH_RD_CMD   = 4'd7;
  localparam logic [3:0] PH_RD_ADDR  = 4'd8;
  localparam logic [3:0] PH_RD_DATA  = 4'd9;
  localparam logic [3:0] PH_WREN     = 4'd10;
  localparam logic [3:0] PH_ERASE    = 4'd11;
  localparam logic [3:0] PH_PP_CMD   = 4'd12;
  localparam logic [3:0] PH_PP_ADDR  = 4'd13;
  localparam logic [3:0] PH_PP_DATA  = 4'd14;

  typedef enum logic [14:0] {
    ST_RST_EN  = 15'h0001,
    ST_DEV_RST = 15'h0002,
    ST_ID_CMD  = 15'h0004,
    ST_ID1     = 15'h0008,
    ST_ID2     = 15'h0010,
    ST_ID3     = 15'h0020,
    ST_IDLE    = 15'h0040,
    ST_RD_CMD  = 15'h0080,
    ST_RD_ADDR = 15'h0100,
    ST_RD_DATA = 15'h0200,
    ST_WREN    = 15'h0400,
    ST_ERASE   = 15'h0800,
    ST_PP_CMD  = 15'h1000,
    ST_PP_ADDR = 15'h2000,
    ST_PP_DATA = 15'h4000
  } state_t;

  typedef struct packed {
    logic        mode;
    logic [23:0] start_address;
    logic [7:0]  expected_maker_id;
  } cfg_t;

  typedef struct packed {
    logic [3:0] phase;
    logic       op_done;
    logic       id_error;
    logic       select_active;
    logic [7:0] tx_byte;
    logic       tx_valid;
  } res_t;

  function automatic logic [3:0] phase_code(input state_t st);
    logic [3:0] code;
    case (st)
      ST_RST_EN:  code = PH_RST_EN;
      ST_DEV_RST: code = PH_DEV_RST;
      ST_ID_CMD:  code = PH_ID_CMD;
      ST_ID1:     code = PH_ID1;
      ST_ID2:     code = PH_ID2;
      ST_ID3:     code = PH_ID3;
      ST_IDLE:    code = PH_IDLE;
      ST_RD_CMD:  code = PH_RD_CMD;
      ST_RD_ADDR: code = PH_RD_ADDR;
      ST_RD_DATA: code = PH_RD_DATA;
      ST_WREN:    code = PH_WREN;
      ST_ERASE:   code = PH_ERASE;
      ST_PP_CMD:  code = PH_PP_CMD;
      ST_PP_ADDR: code = PH_PP_ADDR;
      ST_PP_DATA: code = PH_PP_DATA;
      default:    code = PH_RST_EN;
    endcase
    return code;
  endfunction

endpackage

[rtl/sfcs_regs.sv]
// ----------------------------------------------------------------------------
// sfcs_regs
// APB-style configuration registers: mode, start address, expected maker ID.
// ----------------------------------------------------------------------------
module sfcs_regs
  import sfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic        wr_en;
  logic [1:0]  reg_idx;
  cfg_t        regs;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.mode              <= MODE_READ;
      regs.start_address     <= '0;
      regs.expected_maker_id <= MAKER_ID_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:       regs.mode              <= pwdata[0];
        REG_START_ADDR: regs.start_address     <= pwdata[23:0];
        REG_MAKER_ID:   regs.expected_maker_id <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:       prdata = {31'd0, regs.mode};
      REG_START_ADDR: prdata = {8'd0, regs.start_address};
      REG_MAKER_ID:   prdata = {24'd0, regs.expected_maker_id};
      default:        prdata = '0;
    endcase
  end

  assign cfg = regs;

endmodule

[rtl/sfcs_buf.sv]
// ----------------------------------------------------------------------------
// sfcs_buf
// Data buffer: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module sfcs_buf
  import sfcs_pkg::*;
#(
  parameter int unsigned DEPTH = DEF_BUFFER_BYTES,
  parameter int unsigned IDX_W = 8
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/sfcs_core.sv]
// ----------------------------------------------------------------------------
// sfcs_core
// Command sequencer state and next-byte logic, one request per step.
// ----------------------------------------------------------------------------
module sfcs_core
  import sfcs_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES,
  parameter int unsigned IDX_W        = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             func,
  input  logic [7:0]       rx_byte,
  input  cfg_t             cfg,
  input  logic [7:0]       buf_rd_data,
  output logic             buf_wr_en,
  output logic [IDX_W-1:0] buf_wr_addr,
  output logic [7:0]       buf_wr_data,
  output logic [IDX_W-1:0] buf_rd_addr,
  output res_t             res
);

  localparam int unsigned MAX_BYTES = (BUFFER_BYTES > PAGE_BYTES) ? BUFFER_BYTES : PAGE_BYTES;
  localparam int unsigned CNT_W     = $clog2(MAX_BYTES + 2);
  localparam logic [CNT_W-1:0] BUF_LIMIT  = CNT_W'(BUFFER_BYTES);
  localparam logic [CNT_W-1:0] PAGE_LIMIT = CNT_W'(PAGE_BYTES);
  localparam logic [IDX_W-1:0] IDX_LAST   = IDX_W'(BUFFER_BYTES - 1);

  state_t           state, state_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [IDX_W-1:0] buf_idx, buf_idx_next;
  logic [1:0]       addr_idx, addr_idx_next;
  logic [23:0]      cur_addr, cur_addr_next;

  logic [CNT_W-1:0] count_inc;
  logic [IDX_W-1:0] idx_inc;
  logic [7:0]       addr_sel;
  res_t             r;

  assign count_inc = byte_count + CNT_W'(1);
  assign idx_inc   = (buf_idx == IDX_LAST) ? '0 : buf_idx + IDX_W'(1);

  // Address bytes go out most significant first.
  always_comb begin
    case (addr_idx)
      2'd0:    addr_sel = cur_addr[23:16];
      2'd1:    addr_sel = cur_addr[15:8];
      2'd2:    addr_sel = cur_addr[7:0];
      default: addr_sel = '0;
    endcase
  end

  always_comb begin
    state_next      = state;
    byte_count_next = byte_count;
    buf_idx_next    = buf_idx;
    addr_idx_next   = addr_idx;
    cur_addr_next   = cur_addr;
    buf_wr_en       = 1'b0;
    r               = '0;

    if (func == FUNC_START) begin
      case (state)
        ST_RST_EN, ST_DEV_RST, ST_ID_CMD, ST_ID1, ST_ID2, ST_ID3: begin
          state_next      = ST_RST_EN;
          byte_count_next = '0;
          buf_idx_next    = '0;
          addr_idx_next   = '0;
          r.tx_valid      = 1'b1;
          r.tx_byte       = CMD_RESET_EN;
        end
        ST_IDLE: begin
          byte_count_next = '0;
          buf_idx_next    = '0;
          addr_idx_next   = '0;
          r.tx_valid      = 1'b1;
          if (cfg.mode == MODE_READ) begin
            state_next = ST_RD_CMD;
            r.tx_byte  = CMD_READ;
          end else begin
            state_next = ST_WREN;
            r.tx_byte  = CMD_WRITE_EN;
          end
        end
        ST_RD_CMD, ST_RD_ADDR, ST_RD_DATA, ST_WREN, ST_ERASE,
        ST_PP_CMD, ST_PP_ADDR, ST_PP_DATA: begin
        end
        default: begin
          state_next      = ST_RST_EN;
          byte_count_next = '0;
          buf_idx_next    = '0;
          addr_idx_next   = '0;
          r.tx_valid      = 1'b1;
          r.tx_byte       = CMD_RESET_EN;
        end
      endcase
    end else begin
      case (state)
        ST_RST_EN: begin
          state_next = ST_DEV_RST;
          r.tx_valid = 1'b1;
          r.tx_byte  = CMD_RESET;
        end
        ST_DEV_RST: begin
          state_next = ST_ID_CMD;
          r.tx_valid = 1'b1;
          r.tx_byte  = CMD_READ_ID;
        end
        ST_ID_CMD: begin
          state_next      = ST_ID1;
          r.tx_valid      = 1'b1;
          r.tx_byte       = DUMMY_BYTE;
          r.select_active = 1'b1;
        end
        ST_ID1: begin
          if (rx_byte != cfg.expected_maker_id) begin
            r.id_error      = 1'b1;
            state_next      = ST_RST_EN;
            byte_count_next = '0;
            buf_idx_next    = '0;
            addr_idx_next   = '0;
            r.tx_valid      = 1'b1;
            r.tx_byte       = CMD_RESET_EN;
          end else begin
            state_next      = ST_ID2;
            r.tx_valid      = 1'b1;
            r.tx_byte       = DUMMY_BYTE;
            r.select_active = 1'b1;
          end
        end
        ST_ID2: begin
          state_next      = ST_ID3;
          r.tx_valid      = 1'b1;
          r.tx_byte       = DUMMY_BYTE;
          r.select_active = 1'b1;
        end
        ST_ID3: begin
          state_next    = ST_IDLE;
          cur_addr_next = cfg.start_address;
          r.op_done     = 1'b1;
        end
        ST_IDLE: begin
        end
        ST_RD_CMD, ST_PP_CMD: begin
          state_next      = (state == ST_RD_CMD) ? ST_RD_ADDR : ST_PP_ADDR;
          r.tx_valid      = 1'b1;
          r.tx_byte       = cur_addr[23:16];
          r.select_active = 1'b1;
          addr_idx_next   = 2'd1;
        end
        ST_RD_ADDR, ST_PP_ADDR: begin
          r.tx_valid      = 1'b1;
          r.select_active = 1'b1;
          if (addr_idx != 2'd3) begin
            r.tx_byte     = addr_sel;
            addr_idx_next = addr_idx + 2'd1;
          end else if (state == ST_RD_ADDR) begin
            state_next      = ST_RD_DATA;
            byte_count_next = '0;
            buf_idx_next    = '0;
            r.tx_byte       = DUMMY_BYTE;
          end else begin
            // Buffer index is zero here, so the prefetched byte is entry zero.
            state_next      = ST_PP_DATA;
            r.tx_byte       = buf_rd_data;
            byte_count_next = CNT_W'(1);
            buf_idx_next    = idx_inc;
          end
        end
        ST_RD_DATA: begin
          buf_wr_en = 1'b1;
          if (count_inc >= BUF_LIMIT) begin
            state_next      = ST_IDLE;
            byte_count_next = '0;
            buf_idx_next    = '0;
            r.op_done       = 1'b1;
          end else begin
            byte_count_next = count_inc;
            buf_idx_next    = idx_inc;
            r.tx_valid      = 1'b1;
            r.tx_byte       = DUMMY_BYTE;
            r.select_active = 1'b1;
          end
        end
        ST_WREN: begin
          state_next = ST_ERASE;
          r.tx_valid = 1'b1;
          r.tx_byte  = CMD_CHIP_ERA;
        end
        ST_ERASE: begin
          state_next = ST_PP_CMD;
          r.tx_valid = 1'b1;
          r.tx_byte  = CMD_PAGE_PROG;
        end
        ST_PP_DATA: begin
          if (byte_count >= PAGE_LIMIT) begin
            cur_addr_next   = cur_addr + PAGE_STRIDE;
            state_next      = ST_IDLE;
            byte_count_next = '0;
            buf_idx_next    = '0;
            addr_idx_next   = '0;
            r.op_done       = 1'b1;
          end else begin
            r.tx_valid      = 1'b1;
            r.tx_byte       = buf_rd_data;
            r.select_active = 1'b1;
            byte_count_next = count_inc;
            buf_idx_next    = idx_inc;
          end
        end
        default: begin
          state_next      = ST_RST_EN;
          byte_count_next = '0;
          buf_idx_next    = '0;
          addr_idx_next   = '0;
          r.tx_valid      = 1'b1;
          r.tx_byte       = CMD_RESET_EN;
        end
      endcase
    end
    r.phase = phase_code(state_next);
  end

  assign res         = r;
  assign buf_wr_addr = buf_idx;
  assign buf_wr_data = rx_byte;

  // The read port always fetches the entry that the next step may send.
  assign buf_rd_addr = step ? buf_idx_next : buf_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RST_EN;
      byte_count <= '0;
      buf_idx    <= '0;
      addr_idx   <= '0;
      cur_addr   <= '0;
    end else if (step) begin
      state      <= state_next;
      byte_count <= byte_count_next;
      buf_idx    <= buf_idx_next;
      addr_idx   <= addr_idx_next;
      cur_addr   <= cur_addr_next;
    end
  end

  // Writes happen only on completed read-data bytes.
  assign_wr_phase: assert property (@(posedge clk) disable iff (rst)
    buf_wr_en && step |-> (state == ST_RD_DATA) && (func == FUNC_BYTE_DONE))
    else $error("buffer written outside the read data phase");

  // While reading data the buffer index follows the byte count.
  idx_tracks_count: assert property (@(posedge clk) disable iff (rst)
    state == ST_RD_DATA |-> byte_count == CNT_W'(buf_idx))
    else $error("buffer index lost track of byte count");

  // An ID mismatch sends the sequence back to reset-enable.
  id_err_restart: assert property (@(posedge clk) disable iff (rst)
    step && res.id_error |=> state == ST_RST_EN)
    else $error("ID mismatch did not restart start-up");

  // The flash address moves only on a processed request.
  addr_hold: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(cur_addr))
    else $error("current address changed without a request");

endmodule

[rtl/spi_flash_command_sequencer.sv]
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer
// Byte-level command sequencer of a serial NOR flash master.
//
// Usage: each request on the s_ stream is either a start (tuser = 0) or the
// report of a finished byte exchange (tuser = 1, tdata = byte received). For
// every request exactly one result appears on the m_ stream: the next byte to
// shift out, whether chip select stays asserted, the ID error and done flags
// and the phase after the step. Requests are registered on entry and their
// results are registered on exit; while the result receiver does not stall,
// one request per cycle is sustained. The limit is the state update loop;
// buffer bytes are prefetched from the single-port-read buffer one step
// ahead. Reset puts the sequencer in the reset-enable phase with the flash
// address at zero; the buffer content is undefined until a read fills it.
// When the result receiver stalls, the output register holds its result, the
// input register takes one more request, and s_tready then drops until the
// output drains. The user is to write the registers through the APB port
// only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer
  import sfcs_pkg::*;
#(
  parameter int unsigned BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int unsigned PAGE_BYTES   = DEF_PAGE_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] select_active, [10] id_error,
  // [11] op_done, [15:12] phase
  output logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned IDX_W = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  cfg_t             cfg;
  logic             in_valid;
  logic             in_func;
  logic [7:0]       in_rx;
  logic             step;
  res_t             res;
  res_t             out_res;
  logic             out_valid;
  logic             buf_wr_en;
  logic [IDX_W-1:0] buf_wr_addr;
  logic [7:0]       buf_wr_data;
  logic [IDX_W-1:0] buf_rd_addr;
  logic [7:0]       buf_rd_data;

  assign step     = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_func <= s_tuser;
      in_rx   <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_res;

  sfcs_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  sfcs_buf #(
    .DEPTH (BUFFER_BYTES),
    .IDX_W (IDX_W)
  ) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en && step),
    .wr_addr (buf_wr_addr),
    .wr_data (buf_wr_data),
    .rd_addr (buf_rd_addr),
    .rd_data (buf_rd_data)
  );

  sfcs_core #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .PAGE_BYTES   (PAGE_BYTES),
    .IDX_W        (IDX_W)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .func        (in_func),
    .rx_byte     (in_rx),
    .cfg         (cfg),
    .buf_rd_data (buf_rd_data),
    .buf_wr_en   (buf_wr_en),
    .buf_wr_addr (buf_wr_addr),
    .buf_wr_data (buf_wr_data),
    .buf_rd_addr (buf_rd_addr),
    .res         (res)
  );

endmodule

[verif/spi_flash_command_sequencer_checker.sv]
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_checker
// Watches the request, result and register ports of the flash command
// sequencer, predicts every result from its own copy of the sequencer state
// and compares each delivered result field by field in order.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_checker
  import sfcs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  input  logic        s_tuser,   // [0] func
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [0] tx_valid, [8:1] tx_byte, [9] select_active, [10] id_error,
  // [11] op_done, [15:12] phase
  input  logic [15:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned BUF_BYTES = DEF_BUFFER_BYTES;
  localparam int unsigned PAGE_LEN  = DEF_PAGE_BYTES;

  logic        cfg_mode;
  logic [23:0] cfg_start;
  logic [7:0]  cfg_maker;

  logic [3:0]  phase_now;
  int unsigned xfer_cnt;
  logic [1:0]  addr_pos;
  logic [23:0] flash_addr;
  logic [7:0]  page_buf [BUF_BYTES];

  res_t        pending_results [$];
  int unsigned mismatches = 0;
  int unsigned outstanding = 0;

  // Results still owed at the end count as failures too.
  assign fail_count = mismatches + outstanding;

  function automatic void emit_byte(inout res_t r, input logic [7:0] b, input logic keep_cs);
    r.tx_valid      = 1'b1;
    r.tx_byte       = b;
    r.select_active = keep_cs;
  endfunction

  function automatic void restart_startup(inout res_t r);
    phase_now = PH_RST_EN;
    xfer_cnt  = 0;
    addr_pos  = 2'd0;
    emit_byte(r, CMD_RESET_EN, 1'b0);
  endfunction

  // The flash address goes out most significant byte first.
  function automatic logic [7:0] address_octet(input logic [1:0] pos);
    case (pos)
      2'd0:    return flash_addr[23:16];
      2'd1:    return flash_addr[15:8];
      default: return flash_addr[7:0];
    endcase
  endfunction

  function automatic res_t predict_step(input logic func, input logic [7:0] rx);
    res_t r;
    r = '0;
    if (func == FUNC_START) begin
      if (phase_now <= PH_ID3 || phase_now > PH_PP_DATA) begin
        restart_startup(r);
      end else if (phase_now == PH_IDLE) begin
        xfer_cnt = 0;
        addr_pos = 2'd0;
        if (cfg_mode == MODE_READ) begin
          phase_now = PH_RD_CMD;
          emit_byte(r, CMD_READ, 1'b0);
        end else begin
          phase_now = PH_WREN;
          emit_byte(r, CMD_WRITE_EN, 1'b0);
        end
      end
      // A start while an operation runs is dropped.
    end else begin
      case (phase_now)
        PH_RST_EN: begin
          phase_now = PH_DEV_RST;
          emit_byte(r, CMD_RESET, 1'b0);
        end
        PH_DEV_RST: begin
          phase_now = PH_ID_CMD;
          emit_byte(r, CMD_READ_ID, 1'b0);
        end
        PH_ID_CMD: begin
          phase_now = PH_ID1;
          emit_byte(r, DUMMY_BYTE, 1'b1);
        end
        PH_ID1: begin
          if (rx != cfg_maker) begin
            r.id_error = 1'b1;
            restart_startup(r);
          end else begin
            phase_now = PH_ID2;
            emit_byte(r, DUMMY_BYTE, 1'b1);
          end
        end
        PH_ID2: begin
          phase_now = PH_ID3;
          emit_byte(r, DUMMY_BYTE, 1'b1);
        end
        PH_ID3: begin
          phase_now  = PH_IDLE;
          flash_addr = cfg_start;
          r.op_done  = 1'b1;
        end
        PH_IDLE: begin
        end
        PH_RD_CMD, PH_PP_CMD: begin
          phase_now = (phase_now == PH_RD_CMD) ? PH_RD_ADDR : PH_PP_ADDR;
          emit_byte(r, address_octet(2'd0), 1'b1);
          addr_pos = 2'd1;
        end
        PH_RD_ADDR, PH_PP_ADDR: begin
          if (addr_pos < 2'd3) begin
            emit_byte(r, address_octet(addr_pos), 1'b1);
            addr_pos = addr_pos + 2'd1;
          end else if (phase_now == PH_RD_ADDR) begin
            phase_now = PH_RD_DATA;
            xfer_cnt  = 0;
            emit_byte(r, DUMMY_BYTE, 1'b1);
          end else begin
            phase_now = PH_PP_DATA;
            emit_byte(r, page_buf[0], 1'b1);
            xfer_cnt = 1;
          end
        end
        PH_RD_DATA: begin
          page_buf[xfer_cnt % BUF_BYTES] = rx;
          xfer_cnt++;
          if (xfer_cnt >= BUF_BYTES) begin
            phase_now = PH_IDLE;
            xfer_cnt  = 0;
            r.op_done = 1'b1;
          end else begin
            emit_byte(r, DUMMY_BYTE, 1'b1);
          end
        end
        PH_WREN: begin
          phase_now = PH_ERASE;
          emit_byte(r, CMD_CHIP_ERA, 1'b0);
        end
        PH_ERASE: begin
          phase_now = PH_PP_CMD;
          emit_byte(r, CMD_PAGE_PROG, 1'b0);
        end
        PH_PP_DATA: begin
          if (xfer_cnt >= PAGE_LEN) begin
            flash_addr = flash_addr + PAGE_STRIDE;
            phase_now  = PH_IDLE;
            xfer_cnt   = 0;
            addr_pos   = 2'd0;
            r.op_done  = 1'b1;
          end else begin
            emit_byte(r, page_buf[xfer_cnt % BUF_BYTES], 1'b1);
            xfer_cnt++;
          end
        end
        default: restart_startup(r);
      endcase
    end
    r.phase = phase_now;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    res_t got;
    res_t want;
    if (rst) begin
      cfg_mode   = MODE_READ;
      cfg_start  = '0;
      cfg_maker  = MAKER_ID_RST;
      phase_now  = PH_RST_EN;
      xfer_cnt   = 0;
      addr_pos   = 2'd0;
      flash_addr = '0;
      pending_results.delete();
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_MODE:       cfg_mode  = pwdata[0];
          REG_START_ADDR: cfg_start = pwdata[23:0];
          REG_MAKER_ID:   cfg_maker = pwdata[7:0];
          default: begin
          end
        endcase
      end
      if (s_tvalid && s_tready)
        pending_results.push_back(predict_step(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        got = res_t'(m_tdata);
        if (pending_results.size() == 0) begin
          $error("result %0h delivered with no request outstanding", m_tdata);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(got.tx_valid));
          check_field("tx_byte", want.tx_byte, got.tx_byte);
          check_field("select_active", 8'(want.select_active), 8'(got.select_active));
          check_field("id_error", 8'(want.id_error), 8'(got.id_error));
          check_field("op_done", 8'(want.op_done), 8'(got.op_done));
          check_field("phase", 8'(want.phase), 8'(got.phase));
        end
      end
      outstanding = pending_results.size();
    end
  end

endmodule

[verif/spi_flash_command_sequencer_tb.sv]
// ----------------------------------------------------------------------------
// spi_flash_command_sequencer_tb
// Drives the flash command sequencer through failed, interrupted and good
// start-up sequences, then through buffer reads and page programs with random
// flash replies, stray requests and random stalls on both streams. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module spi_flash_command_sequencer_tb
  import sfcs_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // Requests per operation after its start: command and three address bytes
  // plus the data bytes for a read; two extra commands for a page program.
  localparam int unsigned READ_BYTES  = 4 + DEF_BUFFER_BYTES;
  localparam int unsigned WRITE_BYTES = 6 + DEF_PAGE_BYTES;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  int unsigned fail_count;

  int unsigned requests_sent = 0;
  int unsigned requests_counted = 0;
  int unsigned results_taken = 0;

  always #5 clk = ~clk;

  spi_flash_command_sequencer dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  spi_flash_command_sequencer_checker result_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .pready     (pready),
    .fail_count (fail_count)
  );

  // Sends one request. Gaps are skipped over a stretch of the run so the
  // block also sees back-to-back traffic.
  task automatic send_item(input logic func, input logic [7:0] rx, input bit counted);
    while (!(requests_sent >= 400 && requests_sent < 600) && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= rx;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    requests_sent++;
    if (counted) requests_counted++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (results_taken != requests_sent) @(posedge clk);
  endtask

  task automatic program_reg(input logic [1:0] idx, input logic [31:0] value);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reset-enable, reset and ID command, then the maker byte; the last two ID
  // bytes only when the sequence is to reach idle.
  task automatic run_startup(input logic [7:0] first_id, input bit to_idle);
    repeat (3) send_item(FUNC_BYTE_DONE, 8'($urandom), 1'b1);
    send_item(FUNC_BYTE_DONE, first_id, 1'b1);
    if (to_idle) repeat (2) send_item(FUNC_BYTE_DONE, 8'($urandom), 1'b1);
  endtask

  task automatic run_operation(input bit write_op);
    send_item(FUNC_START, 8'($urandom), 1'b1);
    repeat (write_op ? WRITE_BYTES : READ_BYTES) begin
      // Stray starts in the middle of an operation must be dropped.
      if ($urandom_range(0, 99) < 4) send_item(FUNC_START, 8'($urandom), 1'b0);
      send_item(FUNC_BYTE_DONE, 8'($urandom), 1'b1);
    end
  endtask

  // Result side: random stalls, one long hold-off that backs the block up,
  // and a stretch with no stalls at all.
  initial begin : result_sink
    int unsigned hold_left;
    bit          held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (m_tvalid && m_tready) results_taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held && results_taken >= 300) begin
        held      = 1'b1;
        hold_left = 79;
        m_tready <= 1'b0;
      end else if (results_taken >= 650 && results_taken < 850) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin : stimulus
    logic [7:0]  maker_code;
    int unsigned op_idx;
    bit          do_write;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Start right after reset restarts the start-up sequence.
    send_item(FUNC_START, 8'($urandom), 1'b1);
    // Wrong maker byte against the reset value of the register.
    run_startup(8'h10, 1'b0);
    // Maker byte matches zero, then a start in the ID phase restarts.
    program_reg(REG_MAKER_ID, 32'h0000_0000);
    program_reg(REG_START_ADDR, 32'h0000_0000);
    program_reg(REG_MODE, {31'd0, MODE_READ});
    run_startup(8'h00, 1'b0);
    send_item(FUNC_START, 8'($urandom), 1'b1);
    // All-ones maker code with a reply one below it.
    program_reg(REG_MAKER_ID, 32'h0000_00FF);
    program_reg(REG_START_ADDR, 32'h00FF_FFFF);
    run_startup(8'hFE, 1'b0);
    // Good start-up; the address sits in the last page so it wraps.
    maker_code = 8'($urandom);
    program_reg(REG_MAKER_ID, {24'd0, maker_code});
    program_reg(REG_START_ADDR, {8'd0, 16'hFFFF, 8'($urandom)});
    run_startup(maker_code, 1'b1);
    // A finished byte while idle is dropped.
    send_item(FUNC_BYTE_DONE, 8'($urandom), 1'b0);

    // The first operation reads, so the buffer is full before any program.
    op_idx = 0;
    while (requests_counted < 950) begin
      do_write = (op_idx == 1) || (op_idx > 1 && $urandom_range(0, 1) == 1);
      program_reg(REG_MODE, {31'd0, (do_write ? MODE_WRITE : MODE_READ)});
      if ($urandom_range(0, 2) == 0) program_reg(REG_START_ADDR, $urandom & 32'h00FF_FFFF);
      if ($urandom_range(0, 2) == 0) program_reg(REG_MAKER_ID, $urandom & 32'h0000_00FF);
      run_operation(do_write);
      repeat ($urandom_range(0, 2)) send_item(FUNC_BYTE_DONE, 8'($urandom), 1'b0);
      op_idx++;
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[spi_flash_command_sequencer] OK");
    end else begin
      $display("[spi_flash_command_sequencer] ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[spi_flash_command_sequencer] ERROR");
    $finish;
  end

endmodule
